### rtl/tpcv_pkg.sv
// Shared types, constants and the CRC-32 byte update for the table package validator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package tpcv_pkg;

    // Package layout and limits.
    localparam int NUM_TABLES        = 9;
    localparam int MAX_PACKAGE_BYTES = 65536;
    localparam int HEADER_BYTES      = 32;
    localparam int DIR_ENTRY_BYTES   = 16;
    localparam int DIR_END           = HEADER_BYTES + NUM_TABLES * DIR_ENTRY_BYTES;
    localparam int HDR_WORDS         = 8;
    localparam int HDR_CAPTURE_BYTES = 32;
    localparam int ZERO_FIELD_AT     = 28;
    localparam int ENTRY_WORD_BYTES  = 16;

    // Widths derived from the layout.
    localparam int POS_W  = $clog2(MAX_PACKAGE_BYTES + 1);
    localparam int ENT_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int IDX_W  = 4;
    localparam int MASK_W = 9;

    // CRC-32 constants (reflected form).
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC   = 4'd0,
        REG_VERSION = 4'd1
    } cfg_reg_t;

    // Error codes in priority order.
    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_SHORT   = 3'd1,
        ERR_MAGIC   = 3'd2,
        ERR_VERSION = 3'd3,
        ERR_SIZE    = 3'd4,
        ERR_COUNT   = 3'd5,
        ERR_CRC     = 3'd6,
        ERR_DIR     = 3'd7
    } err_t;

    typedef logic [HDR_WORDS-1:0][31:0]  hdr_words_t;
    typedef logic [NUM_TABLES-1:0][31:0] tbl_words_t;

    // Input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [IDX_W-1:0]  table_index;
        logic [31:0]       entry_crc;
        err_t              error_code;
        logic              package_valid;
        logic [IDX_W-1:0]  bad_entry;
        logic [MASK_W-1:0] present_mask;
        logic [31:0]       hdr_version;
        logic [31:0]       declared_total_size;
        logic [31:0]       declared_table_count;
        logic [31:0]       declared_payload_crc;
        logic [31:0]       declared_package_crc;
        logic              final_item;
    } out_item_t;

    // Running state of one package as seen by the checker.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             overflow;
        hdr_words_t       header;
        tbl_words_t       dir_id;
        tbl_words_t       dir_off;
        tbl_words_t       dir_sz;
        tbl_words_t       dir_crc;
        logic [31:0]      pkg_crc;
        logic [31:0]      pay_crc;
        tbl_words_t       tbl_crc;
    } scan_stat_t;

    // Verdict of one package, held while its result items drain.
    typedef struct packed {
        err_t                  err;
        logic [IDX_W-1:0]      bad;
        logic [NUM_TABLES-1:0] mask;
        tbl_words_t            tcrc;
        logic [31:0]           fv;
        logic [31:0]           tot;
        logic [31:0]           cnt;
        logic [31:0]           pcrc;
        logic [31:0]           kcrc;
    } verdict_t;

    // One byte of reflected CRC-32, bit at a time.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

### rtl/tpcv_scan.sv
// Byte intake: position counter, header and directory capture, and all running CRCs.
// Depends on tpcv_pkg.
`timescale 1ns / 1ps

module tpcv_scan (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   take_i,
    input  logic                   clear_i,
    input  logic [7:0]             data_i,
    output tpcv_pkg::scan_stat_t   stat_o
);
    import tpcv_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic             overflow_reg;
    hdr_words_t       header_reg;
    tbl_words_t       dir_id_reg;
    tbl_words_t       dir_off_reg;
    tbl_words_t       dir_sz_reg;
    tbl_words_t       dir_crc_reg;
    logic [31:0]      pkg_crc_reg;
    logic [31:0]      pay_crc_reg;
    tbl_words_t       tbl_crc_reg;

    logic [31:0]      pkg_crc_next;
    logic [31:0]      pay_crc_next;
    tbl_words_t       tbl_crc_next;
    logic [NUM_TABLES-1:0] tbl_hit;

    logic [31:0]      p32;
    logic [31:0]      rel;
    logic [31:0]      dir_e_full;
    logic [31:0]      dir_r;
    logic [ENT_W-1:0] dir_e;
    logic             in_range;
    logic             step;
    logic             hdr_hit;
    logic             zero_hit;
    logic             dir_hit;
    logic             pay_hit;

    // Decode where the current byte falls in the package.
    assign p32        = 32'(pos_reg);
    assign in_range   = pos_reg < POS_W'(MAX_PACKAGE_BYTES);
    assign step       = take_i && in_range;
    assign hdr_hit    = p32 < 32'(HDR_CAPTURE_BYTES);
    assign zero_hit   = hdr_hit && (p32 >= 32'(ZERO_FIELD_AT));
    assign dir_hit    = (p32 >= 32'(HEADER_BYTES)) && (p32 < 32'(DIR_END));
    assign pay_hit    = p32 >= 32'(DIR_END);
    assign rel        = p32 - 32'(HEADER_BYTES);
    assign dir_e_full = rel / DIR_ENTRY_BYTES;
    assign dir_r      = rel % DIR_ENTRY_BYTES;
    assign dir_e      = dir_e_full[ENT_W-1:0];

    // CRC updates for the whole package, the payload and each table range.
    always_comb begin
        pkg_crc_next = crc32_byte(pkg_crc_reg, zero_hit ? 8'd0 : data_i);
        pay_crc_next = crc32_byte(pay_crc_reg, data_i);
        for (int i = 0; i < NUM_TABLES; i++) begin
            tbl_hit[i] = pay_hit && (p32 >= dir_off_reg[i])
                         && ((p32 - dir_off_reg[i]) < dir_sz_reg[i]);
            tbl_crc_next[i] = crc32_byte(tbl_crc_reg[i], data_i);
        end
    end

    // Run state; cleared at reset and after every package.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_i) begin
            pos_reg      <= '0;
            overflow_reg <= 1'b0;
            header_reg   <= '0;
            pkg_crc_reg  <= CRC_INIT;
            pay_crc_reg  <= CRC_INIT;
            for (int i = 0; i < NUM_TABLES; i++) begin
                tbl_crc_reg[i] <= CRC_INIT;
            end
        end else if (take_i) begin
            if (!in_range) begin
                overflow_reg <= 1'b1;
            end else begin
                pos_reg     <= pos_reg + POS_W'(1);
                pkg_crc_reg <= pkg_crc_next;
                if (hdr_hit) begin
                    header_reg[pos_reg[4:2]][{pos_reg[1:0], 3'b000} +: 8] <= data_i;
                end
                if (pay_hit) begin
                    pay_crc_reg <= pay_crc_next;
                end
                for (int i = 0; i < NUM_TABLES; i++) begin
                    if (tbl_hit[i]) begin
                        tbl_crc_reg[i] <= tbl_crc_next[i];
                    end
                end
            end
        end
    end

    // Directory words are written before any read, so they need no reset.
    always_ff @(posedge aclk) begin
        if (step && dir_hit && (dir_r < 32'(ENTRY_WORD_BYTES))) begin
            for (int i = 0; i < NUM_TABLES; i++) begin
                if (dir_e == ENT_W'(i)) begin
                    case (dir_r[3:2])
                        2'd0:    dir_id_reg[i][{dir_r[1:0], 3'b000} +: 8]  <= data_i;
                        2'd1:    dir_off_reg[i][{dir_r[1:0], 3'b000} +: 8] <= data_i;
                        2'd2:    dir_sz_reg[i][{dir_r[1:0], 3'b000} +: 8]  <= data_i;
                        default: dir_crc_reg[i][{dir_r[1:0], 3'b000} +: 8] <= data_i;
                    endcase
                end
            end
        end
    end

    assign stat_o.pos      = pos_reg;
    assign stat_o.overflow = overflow_reg;
    assign stat_o.header   = header_reg;
    assign stat_o.dir_id   = dir_id_reg;
    assign stat_o.dir_off  = dir_off_reg;
    assign stat_o.dir_sz   = dir_sz_reg;
    assign stat_o.dir_crc  = dir_crc_reg;
    assign stat_o.pkg_crc  = pkg_crc_reg;
    assign stat_o.pay_crc  = pay_crc_reg;
    assign stat_o.tbl_crc  = tbl_crc_reg;

endmodule

### rtl/tpcv_check.sv
// Package verdict: header checks, size checks, CRC checks and the directory walk.
// Depends on tpcv_pkg; purely combinational.
`timescale 1ns / 1ps

module tpcv_check (
    input  tpcv_pkg::scan_stat_t stat_i,
    input  logic [31:0]          exp_magic_i,
    input  logic [31:0]          exp_version_i,
    output tpcv_pkg::verdict_t   verdict_o
);
    import tpcv_pkg::*;

    logic [31:0]           size32;
    logic [31:0]           hsz;
    logic [31:0]           dsz;
    logic [31:0]           tot;
    logic [31:0]           cnt;
    logic [31:0]           dir_bytes;
    logic [31:0]           hdr_dir;
    logic [NUM_TABLES-1:0] fail;
    logic                  found;

    assign size32    = 32'(stat_i.pos);
    assign hsz       = stat_i.header[2];
    assign dsz       = stat_i.header[5];
    assign tot       = stat_i.header[3];
    assign cnt       = stat_i.header[4];
    assign dir_bytes = 32'(cnt * 32'(DIR_ENTRY_BYTES));
    assign hdr_dir   = hsz + dsz;

    // Per-entry checks, all entries side by side.
    always_comb begin
        for (int i = 0; i < NUM_TABLES; i++) begin
            fail[i] = (stat_i.dir_id[i] != 32'(i))
                      || (stat_i.dir_off[i] < 32'(DIR_END))
                      || (stat_i.dir_sz[i] == 32'd0)
                      || (stat_i.dir_off[i] > tot)
                      || (stat_i.dir_sz[i] > (tot - stat_i.dir_off[i]))
                      || (~stat_i.tbl_crc[i] != stat_i.dir_crc[i]);
        end
    end

    // Error priority and the first failing entry.
    always_comb begin
        verdict_o      = '0;
        verdict_o.err  = ERR_SHORT;
        found          = 1'b0;
        if (size32 >= 32'(HEADER_BYTES)) begin
            verdict_o.fv   = stat_i.header[1];
            verdict_o.tot  = tot;
            verdict_o.cnt  = cnt;
            verdict_o.pcrc = stat_i.header[6];
            verdict_o.kcrc = stat_i.header[7];
            if (stat_i.header[0] != exp_magic_i) begin
                verdict_o.err = ERR_MAGIC;
            end else if (stat_i.header[1] != exp_version_i || hsz != 32'(HEADER_BYTES)) begin
                verdict_o.err = ERR_VERSION;
            end else if (stat_i.overflow || tot != size32 || dsz != dir_bytes
                         || tot < hdr_dir) begin
                verdict_o.err = ERR_SIZE;
            end else if (cnt != 32'(NUM_TABLES)) begin
                verdict_o.err = ERR_COUNT;
            end else if (~stat_i.pay_crc != stat_i.header[6]
                         || ~stat_i.pkg_crc != stat_i.header[7]) begin
                verdict_o.err = ERR_CRC;
            end else begin
                verdict_o.err = ERR_OK;
                for (int i = 0; i < NUM_TABLES; i++) begin
                    if (!found) begin
                        if (fail[i]) begin
                            found         = 1'b1;
                            verdict_o.err = ERR_DIR;
                            verdict_o.bad = IDX_W'(i);
                        end else begin
                            verdict_o.mask[i] = 1'b1;
                            verdict_o.tcrc[i] = stat_i.dir_crc[i];
                        end
                    end
                end
            end
        end
    end

endmodule

### rtl/tpcv_result.sv
// Result buffer: holds one package verdict and hands out one result item per table.
// Depends on tpcv_pkg.
`timescale 1ns / 1ps

module tpcv_result (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load_i,
    input  tpcv_pkg::verdict_t    verdict_i,
    output logic                  free_o,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tpcv_pkg::out_item_t   m_payload
);
    import tpcv_pkg::*;

    verdict_t         verdict_reg;
    logic             busy_reg;
    logic [ENT_W-1:0] cnt_reg;
    logic             last_item;

    assign last_item = cnt_reg == ENT_W'(NUM_TABLES - 1);
    assign free_o    = !busy_reg || (m_ready && last_item);
    assign m_valid   = busy_reg;

    // Item sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load_i) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (last_item) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + ENT_W'(1);
        end
    end

    // Verdict payload.
    always_ff @(posedge aclk) begin
        if (load_i) begin
            verdict_reg <= verdict_i;
        end
    end

    // Result item fields.
    always_comb begin
        m_payload.table_index          = IDX_W'(cnt_reg);
        m_payload.entry_crc            = verdict_reg.tcrc[cnt_reg];
        m_payload.error_code           = verdict_reg.err;
        m_payload.package_valid        = verdict_reg.err == ERR_OK;
        m_payload.bad_entry            = verdict_reg.bad;
        m_payload.present_mask         = MASK_W'(verdict_reg.mask);
        m_payload.hdr_version          = verdict_reg.fv;
        m_payload.declared_total_size  = verdict_reg.tot;
        m_payload.declared_table_count = verdict_reg.cnt;
        m_payload.declared_payload_crc = verdict_reg.pcrc;
        m_payload.declared_package_crc = verdict_reg.kcrc;
        m_payload.final_item           = last_item;
    end

endmodule

### rtl/table_package_crc_validator.sv
// Top level of the table package validator: config registers, item flow control, assertions.
// Depends on tpcv_pkg, tpcv_scan, tpcv_check and tpcv_result.
`timescale 1ns / 1ps

// Package bytes are taken one per cycle while s_ready is high, with the header, directory
// and every CRC range updated as each byte arrives. The item that carries last_byte is
// followed by an evaluation state in which the verdict is formed and s_ready is low; that
// state lasts while result items of the previous package are still untaken. Each package
// then yields one result item per directory entry, one per cycle while m_ready is high, and
// the next package streams in while they drain. Bytes past MAX_PACKAGE_BYTES are accepted
// but dropped and reported as a size error unless the magic or version check fails first.
// The two config registers may be written only while idle.
module table_package_crc_validator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [tpcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tpcv_pkg::in_item_t           s_payload,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tpcv_pkg::out_item_t          m_payload
);
    import tpcv_pkg::*;

    logic [31:0] exp_magic_reg;
    logic [31:0] exp_version_reg;
    logic        eval_reg;
    logic        eval_next;
    logic        take;
    logic        load;
    logic        free;
    scan_stat_t  stat;
    verdict_t    verdict;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_magic_reg   <= '0;
            exp_version_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAGIC:   exp_magic_reg   <= cfg_wdata;
                REG_VERSION: exp_version_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Flow control: after its last item, hold off input until the result buffer is free, then close the package.
    assign s_ready = !eval_reg;
    assign take    = s_valid && s_ready;
    assign load    = eval_reg && free;

    always_comb begin
        eval_next = eval_reg;
        if (take && s_payload.last_byte) begin
            eval_next = 1'b1;
        end else if (load) begin
            eval_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_reg <= 1'b0;
        end else begin
            eval_reg <= eval_next;
        end
    end

    tpcv_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take_i  (take),
        .clear_i (load),
        .data_i  (s_payload.data_byte),
        .stat_o  (stat)
    );

    tpcv_check u_check (
        .stat_i        (stat),
        .exp_magic_i   (exp_magic_reg),
        .exp_version_i (exp_version_reg),
        .verdict_o     (verdict)
    );

    tpcv_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_i    (load),
        .verdict_i (verdict),
        .free_o    (free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // A last byte always closes the package before the next item is taken.
    a_close_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_payload.last_byte) |=> !s_ready)
        else $error("item accepted right after a last byte");

    // The final result item reports the final table.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.final_item)
        |-> (m_payload.table_index == IDX_W'(NUM_TABLES - 1)))
        else $error("last result item on the wrong table");

    // A bad entry is named only with a directory error.
    a_bad_only_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.error_code != ERR_DIR) |-> (m_payload.bad_entry == '0))
        else $error("bad entry set without directory error");

    // Table CRCs are reported only for entries that passed.
    a_crc_needs_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.error_code != ERR_OK && m_payload.error_code != ERR_DIR)
        |-> (m_payload.entry_crc == 32'd0 && m_payload.present_mask == '0))
        else $error("table reported on a failed package");

endmodule

### verif/tpcv_result_checker.sv
// Checker for the table package validator: tracks each package byte by byte,
// predicts the result items and compares them with what the block emits.
// Depends on tpcv_pkg for the item types, error codes and layout constants.
`timescale 1ns / 1ps

module tpcv_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tpcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  tpcv_pkg::in_item_t             s_payload,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  tpcv_pkg::out_item_t            m_payload,
    output int                             fail_count,
    output int                             outstanding,
    output int                             results_seen
);
    import tpcv_pkg::*;

    // Configuration copy.
    logic [31:0] want_magic;
    logic [31:0] want_version;

    // Scan state of the package in flight.
    logic [31:0] scan_pos;
    bit          scan_overflow;
    logic [31:0] hdr_word [HDR_WORDS];
    logic [31:0] dir_word [NUM_TABLES*4];
    logic [31:0] whole_crc;
    logic [31:0] pay_crc_run;
    logic [31:0] range_crc [NUM_TABLES];

    out_item_t   pending_results [$];

    // Reflected CRC-32, one byte.
    function automatic logic [31:0] crc_update(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
        end
        return c;
    endfunction

    task automatic clear_scan();
        scan_pos = 0;
        scan_overflow = 1'b0;
        foreach (hdr_word[i]) hdr_word[i] = '0;
        foreach (dir_word[i]) dir_word[i] = '0;
        whole_crc = '1;
        pay_crc_run = '1;
        foreach (range_crc[i]) range_crc[i] = '1;
    endtask

    // Fold one byte into the header, directory and every running CRC.
    task automatic absorb_byte(input logic [7:0] b);
        logic [31:0] p;
        logic [31:0] rel;
        logic [31:0] off;
        logic [31:0] sz;
        logic [7:0]  folded;
        p = scan_pos;
        if (p >= MAX_PACKAGE_BYTES) begin
            scan_overflow = 1'b1;
            return;
        end
        folded = b;
        if (p < HEADER_BYTES) begin
            hdr_word[p[4:2]][p[1:0]*8 +: 8] = b;
            if (p >= ZERO_FIELD_AT) folded = 8'd0;
        end
        whole_crc = crc_update(whole_crc, folded);
        if (p >= HEADER_BYTES && p < DIR_END) begin
            rel = p - HEADER_BYTES;
            dir_word[(rel / DIR_ENTRY_BYTES) * 4 + rel[3:2]][rel[1:0]*8 +: 8] = b;
        end
        if (p >= DIR_END) begin
            pay_crc_run = crc_update(pay_crc_run, b);
            for (int i = 0; i < NUM_TABLES; i++) begin
                off = dir_word[i*4 + 1];
                sz  = dir_word[i*4 + 2];
                if (p >= off && (p - off) < sz) range_crc[i] = crc_update(range_crc[i], b);
            end
        end
        scan_pos = p + 1;
    endtask

    // Form the verdict of a finished package and queue its result items.
    task automatic close_package();
        err_t        verdict;
        logic [31:0] fv, tot, cnt, pcrc, kcrc, hsz, dsz, dsz_calc, hdr_end;
        logic [31:0] id, off, sz, crc;
        logic [3:0]  bad;
        logic [8:0]  mask;
        logic [31:0] tcrc [NUM_TABLES];
        out_item_t   item;
        verdict = ERR_SHORT;
        {fv, tot, cnt, pcrc, kcrc} = '0;
        bad = '0;
        mask = '0;
        foreach (tcrc[i]) tcrc[i] = '0;
        if (scan_pos >= HEADER_BYTES) begin
            fv = hdr_word[1];
            hsz = hdr_word[2];
            tot = hdr_word[3];
            cnt = hdr_word[4];
            dsz = hdr_word[5];
            pcrc = hdr_word[6];
            kcrc = hdr_word[7];
            dsz_calc = cnt * DIR_ENTRY_BYTES;
            hdr_end = hsz + dsz;
            if (hdr_word[0] != want_magic) begin
                verdict = ERR_MAGIC;
            end else if (fv != want_version || hsz != HEADER_BYTES) begin
                verdict = ERR_VERSION;
            end else if (scan_overflow || tot != scan_pos || dsz != dsz_calc ||
                         tot < hdr_end) begin
                verdict = ERR_SIZE;
            end else if (cnt != NUM_TABLES) begin
                verdict = ERR_COUNT;
            end else if (~pay_crc_run != pcrc || ~whole_crc != kcrc) begin
                verdict = ERR_CRC;
            end else begin
                verdict = ERR_OK;
                for (int i = 0; i < NUM_TABLES; i++) begin
                    id  = dir_word[i*4];
                    off = dir_word[i*4 + 1];
                    sz  = dir_word[i*4 + 2];
                    crc = dir_word[i*4 + 3];
                    if (id != i || off < DIR_END || sz == 0 || off > tot ||
                        sz > tot - off || ~range_crc[i] != crc) begin
                        verdict = ERR_DIR;
                        bad = 4'(i);
                        break;
                    end
                    mask[i] = 1'b1;
                    tcrc[i] = crc;
                end
            end
        end
        for (int i = 0; i < NUM_TABLES; i++) begin
            item.table_index          = 4'(i);
            item.entry_crc            = tcrc[i];
            item.error_code           = verdict;
            item.package_valid        = (verdict == ERR_OK);
            item.bad_entry            = bad;
            item.present_mask         = mask;
            item.hdr_version          = fv;
            item.declared_total_size  = tot;
            item.declared_table_count = cnt;
            item.declared_payload_crc = pcrc;
            item.declared_package_crc = kcrc;
            item.final_item           = (i == NUM_TABLES - 1);
            pending_results.push_back(item);
        end
        clear_scan();
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: result mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Field-by-field comparison against the oldest expectation.
    task automatic compare_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            report("unexpected item", 32'd1, 32'd0);
            return;
        end
        want = pending_results.pop_front();
        if (got.table_index !== want.table_index)
            report("table_index", got.table_index, want.table_index);
        if (got.entry_crc !== want.entry_crc)
            report("entry_crc", got.entry_crc, want.entry_crc);
        if (got.error_code !== want.error_code)
            report("error_code", got.error_code, want.error_code);
        if (got.package_valid !== want.package_valid)
            report("package_valid", got.package_valid, want.package_valid);
        if (got.bad_entry !== want.bad_entry)
            report("bad_entry", got.bad_entry, want.bad_entry);
        if (got.present_mask !== want.present_mask)
            report("present_mask", got.present_mask, want.present_mask);
        if (got.hdr_version !== want.hdr_version)
            report("hdr_version", got.hdr_version, want.hdr_version);
        if (got.declared_total_size !== want.declared_total_size)
            report("declared_total_size", got.declared_total_size, want.declared_total_size);
        if (got.declared_table_count !== want.declared_table_count)
            report("declared_table_count", got.declared_table_count,
                   want.declared_table_count);
        if (got.declared_payload_crc !== want.declared_payload_crc)
            report("declared_payload_crc", got.declared_payload_crc,
                   want.declared_payload_crc);
        if (got.declared_package_crc !== want.declared_package_crc)
            report("declared_package_crc", got.declared_package_crc,
                   want.declared_package_crc);
        if (got.final_item !== want.final_item)
            report("final_item", got.final_item, want.final_item);
    endtask

    initial begin
        fail_count = 0;
        results_seen = 0;
        outstanding = 0;
    end

    // Everything is sampled at the rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            want_magic <= '0;
            want_version <= '0;
            clear_scan();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAGIC:   want_magic <= cfg_wdata;
                    REG_VERSION: want_version <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                compare_result(m_payload);
                results_seen++;
            end
            if (s_valid && s_ready) begin
                absorb_byte(s_payload.data_byte);
                if (s_payload.last_byte) close_package();
            end
        end
        outstanding = pending_results.size();
    end

endmodule

### verif/tb_table_package_crc_validator.sv
// Testbench top for the table package validator: builds packages, drives the
// byte and config ports, paces the result side and gives the verdict.
// Depends on tpcv_pkg, the block and tpcv_result_checker.
`timescale 1ns / 1ps

module tb_table_package_crc_validator;
    import tpcv_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD = 600;
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 4'd9;

    // Ways of spoiling a package.
    typedef enum int {
        F_NONE, F_MAGIC, F_VERSION, F_HSIZE, F_TOTAL, F_DIRSIZE, F_COUNT_WRAP,
        F_PAYLOAD_CRC, F_PACKAGE_CRC, F_ID, F_OFF_LOW, F_OFF_HIGH, F_SIZE_ZERO,
        F_SIZE_OVER, F_TABLE_CRC, F_TRUNCATE, F_NOISE
    } fault_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    in_item_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_item_t   m_payload;

    int fail_count, outstanding, results_seen;
    int packages_sent = 0;
    int burst_left = 0;
    bit no_gaps = 0;
    int hold_ticket = 0;
    logic [31:0] cur_magic = '0;
    logic [31:0] cur_version = '0;
    logic [7:0]  pkt [$];

    always #10 aclk = ~aclk;

    table_package_crc_validator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    tpcv_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .fail_count(fail_count), .outstanding(outstanding), .results_seen(results_seen)
    );

    // Receiver: a changing stall pattern, plus a long hold-off on request.
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_left = 0;
    int hold_served = 0;
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (rx_cycle % 4 != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog on cycles with no item accepted on either side.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("tb_table_package_crc_validator: done, errors");
                $finish;
            end
        end
    end

    function automatic logic [31:0] crc_over(input int from, input int n);
        logic [31:0] c;
        logic [7:0]  b;
        c = '1;
        for (int i = from; i < from + n; i++) begin
            b = (i >= ZERO_FIELD_AT && i < HEADER_BYTES) ? 8'd0 : pkt[i];
            c = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++) c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
        end
        return ~c;
    endfunction

    task automatic put_word(input int at, input logic [31:0] w);
        for (int k = 0; k < 4; k++) pkt[at + k] = w[k*8 +: 8];
    endtask

    function automatic logic [31:0] get_word(input int at);
        return {pkt[at + 3], pkt[at + 2], pkt[at + 1], pkt[at]};
    endfunction

    // Build a well-formed package with plen payload bytes, then apply one fault.
    task automatic build_package(input int plen, input fault_t fault);
        int tot, off, sz, j, base;
        pkt.delete();
        tot = DIR_END + plen;
        for (int i = 0; i < tot; i++) pkt.push_back(8'($urandom_range(0, 255)));
        put_word(0, cur_magic);
        put_word(4, cur_version);
        put_word(8, HEADER_BYTES);
        put_word(12, tot);
        put_word(16, NUM_TABLES);
        put_word(20, NUM_TABLES * DIR_ENTRY_BYTES);
        for (int i = 0; i < NUM_TABLES; i++) begin
            base = HEADER_BYTES + i * DIR_ENTRY_BYTES;
            off = $urandom_range(DIR_END, tot - 1);
            sz = $urandom_range(1, tot - off);
            put_word(base, i);
            put_word(base + 4, off);
            put_word(base + 8, sz);
            put_word(base + 12, crc_over(off, sz));
        end
        // Directory faults must survive the CRC checks, so they go in first.
        j = $urandom_range(0, NUM_TABLES - 1);
        base = HEADER_BYTES + j * DIR_ENTRY_BYTES;
        case (fault)
            F_ID:        put_word(base, get_word(base) ^ (32'd1 << $urandom_range(0, 31)));
            F_OFF_LOW:   put_word(base + 4, $urandom_range(0, DIR_END - 1));
            F_OFF_HIGH:  put_word(base + 4, tot + $urandom_range(1, 1000));
            F_SIZE_ZERO: put_word(base + 8, 0);
            F_SIZE_OVER: put_word(base + 8, tot - get_word(base + 4) + $urandom_range(1, 50));
            F_TABLE_CRC: put_word(base + 12, get_word(base + 12) ^ (32'd1 << $urandom_range(0, 31)));
            default: ;
        endcase
        put_word(24, crc_over(DIR_END, plen));
        put_word(28, crc_over(0, tot));
        case (fault)
            F_MAGIC:       put_word(0, cur_magic ^ (32'd1 << $urandom_range(0, 31)));
            F_VERSION:     put_word(4, cur_version ^ (32'd1 << $urandom_range(0, 31)));
            F_HSIZE:       put_word(8, $urandom_range(0, 1) ? 32'd0 : 32'd33);
            F_TOTAL:       put_word(12, tot + $urandom_range(1, 3));
            F_DIRSIZE:     put_word(20, 32'd128);
            // Count times entry size wraps to zero, so only the count check trips.
            F_COUNT_WRAP: begin
                put_word(16, 32'h1000_0000);
                put_word(20, 32'd0);
            end
            F_PAYLOAD_CRC: put_word(24, get_word(24) ^ (32'd1 << $urandom_range(0, 31)));
            F_PACKAGE_CRC: put_word(28, get_word(28) ^ (32'd1 << $urandom_range(0, 31)));
            F_TRUNCATE:    repeat ($urandom_range(1, plen)) void'(pkt.pop_back());
            F_NOISE:       foreach (pkt[i]) pkt[i] = 8'($urandom_range(0, 255));
            default: ;
        endcase
    endtask

    // Offer one byte item and wait until it is taken; bursts with random gaps.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!no_gaps && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_valid <= 1'b1;
        s_payload <= '{data_byte: b, last_byte: last};
        if (burst_left > 0) burst_left--;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_package();
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
        packages_sent++;
    endtask

    task automatic send_short(input int n);
        pkt.delete();
        repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
        send_package();
    endtask

    // Drop valid and wait until every expected result item has come.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [31:0] magic, input logic [31:0] version);
        wait_drained();
        write_reg(REG_MAGIC, magic);
        write_reg(REG_VERSION, version);
        write_reg(UNMAPPED_REG, $urandom);
        cur_magic = magic;
        cur_version = version;
    endtask

    fault_t pick;
    int choice;

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(negedge aclk);

        // Directed part: reset values of the registers first, then one of each case.
        build_package(1, F_NONE);
        send_package();
        set_config(32'h4B50_5431, 32'h0000_0003);
        send_short(1);
        send_short(31);
        send_short(32);
        build_package(1, F_NONE);
        send_package();
        for (int f = F_MAGIC; f <= F_NOISE; f++) begin
            build_package($urandom_range(4, 24), fault_t'(f));
            send_package();
        end

        // Overlong package: valid header, then bytes past the size limit.
        no_gaps = 1;
        build_package(MAX_PACKAGE_BYTES - DIR_END, F_NONE);
        repeat (3) pkt.push_back(8'($urandom_range(0, 255)));
        send_package();
        no_gaps = 0;

        // Random part over several settings, extremes among them.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_config(32'h0, 32'h0);
                1: set_config($urandom, $urandom);
                2: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: set_config($urandom, $urandom);
            endcase
            for (int n = 0; n < 6; n++) begin
                if (phase == 1 && n == 1) hold_ticket <= hold_ticket + 1;
                choice = $urandom_range(0, 99);
                if (choice < 60) pick = F_NONE;
                else if (choice < 65) pick = F_NOISE;
                else pick = fault_t'($urandom_range(F_MAGIC, F_TRUNCATE));
                if (choice >= 95) send_short($urandom_range(1, 40));
                else begin
                    build_package($urandom_range(1, 64), pick);
                    send_package();
                end
            end
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        $display("Sent %0d packages, from short and overlong to every fault class,", packages_sent);
        $display("over four register settings; %0d result items checked.", results_seen);
        if (fail_count == 0) begin
            $display("tb_table_package_crc_validator: done, clean");
        end else begin
            $display("tb_table_package_crc_validator: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/tpcv_pkg.sv
rtl/tpcv_scan.sv
rtl/tpcv_check.sv
rtl/tpcv_result.sv
rtl/table_package_crc_validator.sv
verif/tpcv_result_checker.sv
verif/tb_table_package_crc_validator.sv
